// ===== rtl/gfov_pkg.sv =====
// Shared types, constants and table functions for the grid ray-cast field of view core.
`timescale 1ns / 1ps
package gfov_pkg;

  localparam int COORD_W   = 8;
  localparam int ANGLE_CNT = 72;
  localparam int RAY_CNT   = 80;
  localparam int SIN_SHIFT = 54;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_WALL  = 2'd0,
    OP_VIEW  = 2'd1,
    OP_QUERY = 2'd2,
    OP_MARK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_UNSEEN   = 2'd0,
    ST_VISIBLE  = 2'd1,
    ST_EXPLORED = 2'd2
  } status_t;

  typedef struct packed {
    op_t    op;
    coord_t x;
    coord_t y;
    logic   wall;
    logic   on_map;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [16:0] quarter_cos(input logic [4:0] k);
    logic [16:0] v;
    begin
      case (k)
        5'd0:  v = 17'd65536;
        5'd1:  v = 17'd65287;
        5'd2:  v = 17'd64540;
        5'd3:  v = 17'd63303;
        5'd4:  v = 17'd61584;
        5'd5:  v = 17'd59396;
        5'd6:  v = 17'd56756;
        5'd7:  v = 17'd53684;
        5'd8:  v = 17'd50203;
        5'd9:  v = 17'd46341;
        5'd10: v = 17'd42126;
        5'd11: v = 17'd37590;
        5'd12: v = 17'd32768;
        5'd13: v = 17'd27697;
        5'd14: v = 17'd22415;
        5'd15: v = 17'd16962;
        5'd16: v = 17'd11380;
        5'd17: v = 17'd5712;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [17:0] cos_q16(input logic [6:0] k);
    logic [16:0] m;
    logic        neg;
    begin
      if (k <= 7'd18) begin
        m = quarter_cos(5'(k));
        neg = 1'b0;
      end else if (k <= 7'd36) begin
        m = quarter_cos(5'(7'd36 - k));
        neg = 1'b1;
      end else if (k <= 7'd54) begin
        m = quarter_cos(5'(k - 7'd36));
        neg = 1'b1;
      end else begin
        m = quarter_cos(5'(7'd72 - k));
        neg = 1'b0;
      end
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  endfunction

  function automatic logic signed [6:0] scale_trunc(input logic [4:0] r,
                                                    input logic signed [17:0] q);
    logic [16:0] mag;
    logic [21:0] prod;
    logic [5:0]  v;
    begin
      mag  = q[17] ? 17'(-q) : 17'(q);
      prod = 22'(r) * 22'(mag);
      v    = prod[21:16];
      return q[17] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    end
  endfunction

  // direction components of the axis and diagonal rays, -1, 0 or +1
  function automatic logic signed [1:0] axis_dx(input logic [2:0] j);
    logic signed [1:0] d;
    begin
      case (j)
        3'd0, 3'd3, 3'd5: d = -2'sd1;
        3'd1, 3'd6:       d = 2'sd0;
        default:          d = 2'sd1;
      endcase
      return d;
    end
  endfunction

  function automatic logic signed [1:0] axis_dy(input logic [2:0] j);
    logic signed [1:0] d;
    begin
      case (j)
        3'd0, 3'd1, 3'd2: d = -2'sd1;
        3'd3, 3'd4:       d = 2'sd0;
        default:          d = 2'sd1;
      endcase
      return d;
    end
  endfunction

endpackage

// ===== rtl/gfov_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module gfov_front import gfov_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_op,
  input  logic [5:0]   in_tile_x,
  input  logic [5:0]   in_tile_y,
  input  logic         in_wall_bit,
  output q_head_t      head,
  input  logic         take
);

  item_t       q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        push, pop;
  item_t       new_item;

  assign busy = (count_r == 2'd2);
  assign push = start && !busy;
  assign pop  = take && (count_r != 2'd0);

  always_comb begin
    new_item.op     = op_t'(in_op);
    new_item.x      = coord_t'({2'b00, in_tile_x});
    new_item.y      = coord_t'({2'b00, in_tile_y});
    new_item.wall   = in_wall_bit;
    new_item.on_map = (int'(in_tile_x) < MAP_WIDTH) && (int'(in_tile_y) < MAP_HEIGHT);
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/gfov_back.sv =====
// Back end: tile maps, view clear, ray walker and status read-out.
`timescale 1ns / 1ps
module gfov_back import gfov_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  q_head_t    head,
  output logic       take,
  input  logic       cfg_valid,
  input  logic [4:0] cfg_sight_radius,
  output logic       out_valid,
  output logic [1:0] out_status
);

  localparam int CW = $clog2(MAP_WIDTH);
  localparam int RW = $clog2(MAP_HEIGHT);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_QRY, S_CLR, S_RAY_END, S_RAY_SET, S_STEP_A, S_STEP_B
  } state_t;

  logic [MAP_WIDTH-1:0] wall_mem [MAP_HEIGHT];
  logic [MAP_WIDTH-1:0] vis_mem  [MAP_HEIGHT];
  logic [MAP_WIDTH-1:0] expl_mem [MAP_HEIGHT];
  logic [MAP_WIDTH-1:0] wall_row_r, vis_row_r, expl_row_r;

  state_t        state_r, state_nxt;
  logic [4:0]    radius_r;
  logic [RW-1:0] clr_row_r, clr_row_nxt;
  logic [6:0]    ray_r, ray_nxt;
  coord_t        x0_r, y0_r, x1_r, y1_r, x_r, y_r;
  coord_t        x0_nxt, y0_nxt, x1_nxt, y1_nxt, x_nxt, y_nxt;
  logic [5:0]    dx_r, dy_r, dx_nxt, dy_nxt;
  logic          sxn_r, syn_r, sxn_nxt, syn_nxt;
  logic signed [8:0] err_r, err_nxt;
  logic [CW-1:0] qcol_r, qcol_nxt;
  logic          qon_r, qon_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic          wall_we, wall_wd, mark, clr_vis, clr_expl, rd_en;
  logic [RW-1:0] row;
  logic [CW-1:0] col;

  logic signed [17:0] qc, qs;
  logic signed [6:0]  vx, vy;
  logic [2:0]         axj;
  coord_t             diffx, diffy, ox, oy;
  logic [5:0]         aox, aoy;
  logic [12:0]        d2;
  logic [5:0]         rp1;
  logic [11:0]        lim;
  logic               cur_on, at_end, last_ray;
  logic signed [9:0]  e2;
  logic               xadv, yadv;
  logic [6:0]         sin_k;

  function automatic logic on_map(input coord_t x, input coord_t y);
    return (x >= 0) && (y >= 0) && (int'(x) < MAP_WIDTH) && (int'(y) < MAP_HEIGHT);
  endfunction

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_comb begin
    sin_k = (ray_r >= 7'd18) ? ray_r - 7'd18 : ray_r + 7'(SIN_SHIFT);
    qc    = cos_q16(ray_r);
    qs    = cos_q16(sin_k);
    vx    = scale_trunc(radius_r, qc);
    vy    = scale_trunc(radius_r, qs);
    axj   = 3'(ray_r - 7'(ANGLE_CNT));
    diffx = x1_r - x0_r;
    diffy = y1_r - y0_r;
    ox    = x_r - x0_r;
    oy    = y_r - y0_r;
    aox   = ox[COORD_W-1] ? 6'(-ox) : 6'(ox);
    aoy   = oy[COORD_W-1] ? 6'(-oy) : 6'(oy);
    d2    = 13'(12'(aox) * 12'(aox)) + 13'(12'(aoy) * 12'(aoy));
    rp1   = 6'(radius_r) + 6'd1;
    lim   = 12'(rp1) * 12'(rp1);
    cur_on   = on_map(x_r, y_r);
    at_end   = (x_r == x1_r) && (y_r == y1_r);
    last_ray = (ray_r == 7'(RAY_CNT - 1));
    e2    = {err_r[8], err_r} <<< 1;
    xadv  = e2 > -$signed({4'b0000, dy_r});
    yadv  = e2 < $signed({4'b0000, dx_r});
  end

  always_comb begin
    state_nxt      = state_r;
    clr_row_nxt    = clr_row_r;
    ray_nxt        = ray_r;
    x0_nxt = x0_r; y0_nxt = y0_r; x1_nxt = x1_r; y1_nxt = y1_r;
    x_nxt  = x_r;  y_nxt  = y_r;
    dx_nxt = dx_r; dy_nxt = dy_r; sxn_nxt = sxn_r; syn_nxt = syn_r;
    err_nxt        = err_r;
    qcol_nxt       = qcol_r;
    qon_nxt        = qon_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_UNSEEN;
    take     = 1'b0;
    wall_we  = 1'b0;
    wall_wd  = head.item.wall;
    mark     = 1'b0;
    clr_vis  = 1'b0;
    clr_expl = 1'b0;
    rd_en    = 1'b0;
    row      = y_r[RW-1:0];
    col      = x_r[CW-1:0];

    case (state_r)
      S_INIT: begin
        clr_vis  = 1'b1;
        clr_expl = 1'b1;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == RW'(MAP_HEIGHT - 1)) begin
          clr_row_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        row = head.item.y[RW-1:0];
        col = head.item.x[CW-1:0];
        if (head.valid) begin
          take = 1'b1;
          case (head.item.op)
            OP_WALL: begin
              wall_we       = head.item.on_map;
              out_valid_nxt = 1'b1;
            end
            OP_MARK: begin
              mark          = head.item.on_map;
              out_valid_nxt = 1'b1;
            end
            OP_QUERY: begin
              rd_en     = 1'b1;
              qcol_nxt  = head.item.x[CW-1:0];
              qon_nxt   = head.item.on_map;
              state_nxt = S_QRY;
            end
            default: begin
              x0_nxt      = head.item.x;
              y0_nxt      = head.item.y;
              ray_nxt     = '0;
              clr_row_nxt = '0;
              state_nxt   = S_CLR;
            end
          endcase
        end
      end
      S_QRY: begin
        out_valid_nxt = 1'b1;
        if (qon_r && vis_row_r[qcol_r]) out_status_nxt = ST_VISIBLE;
        else if (qon_r && expl_row_r[qcol_r]) out_status_nxt = ST_EXPLORED;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        clr_vis     = 1'b1;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == RW'(MAP_HEIGHT - 1)) begin
          clr_row_nxt = '0;
          state_nxt   = S_RAY_END;
        end
      end
      S_RAY_END: begin
        if (ray_r < 7'(ANGLE_CNT)) begin
          x1_nxt = x0_r + COORD_W'(vx);
          y1_nxt = y0_r + COORD_W'(vy);
        end else begin
          case (axis_dx(axj))
            -2'sd1:  x1_nxt = x0_r - COORD_W'(radius_r);
            2'sd1:   x1_nxt = x0_r + COORD_W'(radius_r);
            default: x1_nxt = x0_r;
          endcase
          case (axis_dy(axj))
            -2'sd1:  y1_nxt = y0_r - COORD_W'(radius_r);
            2'sd1:   y1_nxt = y0_r + COORD_W'(radius_r);
            default: y1_nxt = y0_r;
          endcase
        end
        state_nxt = S_RAY_SET;
      end
      S_RAY_SET: begin
        dx_nxt  = diffx[COORD_W-1] ? 6'(-diffx) : 6'(diffx);
        dy_nxt  = diffy[COORD_W-1] ? 6'(-diffy) : 6'(diffy);
        sxn_nxt = !(x0_r < x1_r);
        syn_nxt = !(y0_r < y1_r);
        err_nxt = $signed({3'b000, dx_nxt}) - $signed({3'b000, dy_nxt});
        x_nxt   = x0_r;
        y_nxt   = y0_r;
        state_nxt = S_STEP_A;
      end
      S_STEP_A: begin
        if (!cur_on || d2 >= {1'b0, lim}) begin
          state_nxt = S_RAY_END;
        end else begin
          mark  = 1'b1;
          rd_en = 1'b1;
          state_nxt = at_end ? S_RAY_END : S_STEP_B;
        end
        if (state_nxt == S_RAY_END) begin
          ray_nxt = ray_r + 7'd1;
          if (last_ray) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_STEP_B: begin
        if (wall_row_r[x_r[CW-1:0]]) begin
          ray_nxt   = ray_r + 7'd1;
          state_nxt = S_RAY_END;
          if (last_ray) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          err_nxt = err_r - (xadv ? $signed({3'b000, dy_r}) : 9'sd0)
                          + (yadv ? $signed({3'b000, dx_r}) : 9'sd0);
          if (xadv) x_nxt = sxn_r ? x_r - 8'sd1 : x_r + 8'sd1;
          if (yadv) y_nxt = syn_r ? y_r - 8'sd1 : y_r + 8'sd1;
          state_nxt = S_STEP_A;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clr_expl) wall_mem[clr_row_r] <= '0;
    else if (wall_we) wall_mem[row][col] <= wall_wd;
    if (clr_vis) vis_mem[clr_row_r] <= '0;
    else if (mark && state_r == S_STEP_A) vis_mem[row][col] <= 1'b1;
    if (clr_expl) expl_mem[clr_row_r] <= '0;
    else if (mark) expl_mem[row][col] <= 1'b1;
    if (rd_en) begin
      wall_row_r <= wall_mem[row];
      vis_row_r  <= vis_mem[row];
      expl_row_r <= expl_mem[row];
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt; y0_r <= y0_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    x_r  <= x_nxt;  y_r  <= y_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; sxn_r <= sxn_nxt; syn_r <= syn_nxt;
    err_r  <= err_nxt;
    qcol_r <= qcol_nxt;
    qon_r  <= qon_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_row_r   <= '0;
      ray_r       <= '0;
      radius_r    <= 5'd8;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      ray_r       <= ray_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) radius_r <= cfg_sight_radius;
    end
  end

endmodule

// ===== rtl/grid_raycast_field_of_view_core.sv =====
// Top level of the grid ray-cast field of view core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  command  | start / busy           | in_op, in_tile_x, in_tile_y, in_wall_bit
//  result   | out_valid (one cycle)  | out_status
//  config   | cfg_valid / cfg_ready  | cfg_sight_radius
//
// An accepted command enters the two-entry queue, whose head the back end reads.
// Wall writes and marks act in the idle state; a query reads the map rows, then
// gives the status. A view compute clears the visible map row by row, then per ray
// sets the end point and step terms, tests tiles in turn and checks the wall of
// each marked tile short of the ray's end. After reset the back end clears the
// wall, visible and explored maps row by row; commands queue meanwhile. busy rises
// when the queue is full. The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
module grid_raycast_field_of_view_core import gfov_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [5:0] in_tile_x,
  input  logic [5:0] in_tile_y,
  input  logic       in_wall_bit,
  output logic       out_valid,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_sight_radius
);

  q_head_t head;
  logic    take;

  assign cfg_ready = 1'b1;

  gfov_front #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .in_wall_bit(in_wall_bit), .head(head), .take(take)
  );

  gfov_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .take(take),
    .cfg_valid(cfg_valid & cfg_ready), .cfg_sight_radius(cfg_sight_radius),
    .out_valid(out_valid), .out_status(out_status)
  );

endmodule

// ===== dv/gfov_checker.sv =====
// Checker for the field of view core: tracks its maps and compares every result.
`timescale 1ns / 1ps
module gfov_checker import gfov_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_op,
  input  logic [5:0] in_tile_x,
  input  logic [5:0] in_tile_y,
  input  logic       in_wall_bit,
  input  logic       out_valid,
  input  logic [1:0] out_status,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [4:0] cfg_sight_radius,
  output int         fail_count,
  output int         pending
);

  localparam int QCOS [19] = '{65536, 65287, 64540, 63303, 61584, 59396, 56756, 53684,
                               50203, 46341, 42126, 37590, 32768, 27697, 22415, 16962,
                               11380, 5712, 0};

  bit        wall_tiles [4096];
  bit        lit_tiles  [4096];
  bit        seen_tiles [4096];
  int        view_radius = 8;
  status_t   status_due [$];

  function automatic int cos_5deg(int k);
    k = k % 72;
    if (k <= 18) return QCOS[k];
    if (k <= 36) return -QCOS[36 - k];
    if (k <= 54) return -QCOS[k - 36];
    return QCOS[72 - k];
  endfunction

  function automatic int end_offset(int q);
    int mag;
    mag = (q < 0) ? -q : q;
    mag = (view_radius * mag) >>> 16;
    return (q < 0) ? -mag : mag;
  endfunction

  function automatic void trace_ray(int x0, int y0, int x1, int y1);
    int dx, dy, sx, sy, err, e2, x, y, lim, t;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    x = x0;
    y = y0;
    lim = (view_radius + 1) * (view_radius + 1);
    forever begin
      if (x < 0 || x > 63 || y < 0 || y > 63) break;
      if ((x - x0) * (x - x0) + (y - y0) * (y - y0) >= lim) break;
      t = y * 64 + x;
      lit_tiles[t] = 1'b1;
      seen_tiles[t] = 1'b1;
      if (x == x1 && y == y1) break;
      if (wall_tiles[t]) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endfunction

  function automatic void sweep_view(int cx, int cy);
    int dxs [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int dys [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    foreach (lit_tiles[i]) lit_tiles[i] = 1'b0;
    for (int k = 0; k < 72; k++)
      trace_ray(cx, cy, cx + end_offset(cos_5deg(k)), cy + end_offset(cos_5deg(k + 54)));
    for (int j = 0; j < 8; j++)
      trace_ray(cx, cy, cx + dxs[j] * view_radius, cy + dys[j] * view_radius);
  endfunction

  function automatic status_t apply_command(op_t op, int x, int y, bit w);
    int t;
    t = y * 64 + x;
    case (op)
      OP_WALL: wall_tiles[t] = w;
      OP_VIEW: sweep_view(x, y);
      OP_MARK: seen_tiles[t] = 1'b1;
      default: begin
        if (lit_tiles[t]) return ST_VISIBLE;
        if (seen_tiles[t]) return ST_EXPLORED;
      end
    endcase
    return ST_UNSEEN;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    status_t due;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) view_radius = cfg_sight_radius;
      if (start && !busy)
        status_due.push_back(apply_command(op_t'(in_op), in_tile_x, in_tile_y, in_wall_bit));
      if (out_valid) begin
        if (status_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, out_status);
          fail_count++;
        end else begin
          due = status_due.pop_front();
          if (out_status !== due) begin
            $display("%0t: status expected %0d, actual %0d", $time, due, out_status);
            fail_count++;
          end
        end
      end
      pending = status_due.size();
    end
  end

endmodule

// ===== dv/grid_raycast_field_of_view_core_tb.sv =====
// Top of the field of view core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module grid_raycast_field_of_view_core_tb import gfov_pkg::*;;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_op;
  logic [5:0] in_tile_x;
  logic [5:0] in_tile_y;
  logic       in_wall_bit;
  logic       out_valid;
  logic [1:0] out_status;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_sight_radius;
  int         fail_count;
  int         pending;
  int         burst_left;
  int         cur_radius;
  int         cx, cy;

  grid_raycast_field_of_view_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .in_wall_bit(in_wall_bit), .out_valid(out_valid), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_sight_radius(cfg_sight_radius)
  );

  gfov_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .in_wall_bit(in_wall_bit), .out_valid(out_valid), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_sight_radius(cfg_sight_radius),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_command(op_t op, int x, int y, bit w);
    start <= 1'b1;
    in_op <= op;
    in_tile_x <= 6'(x);
    in_tile_y <= 6'(y);
    in_wall_bit <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_radius(int r);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_sight_radius <= 5'(r);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_radius = r;
  endtask

  task automatic random_command();
    int pick;
    int x, y;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      x = (cx + $urandom_range(0, 2 * cur_radius + 2) - cur_radius - 1) & 63;
      y = (cy + $urandom_range(0, 2 * cur_radius + 2) - cur_radius - 1) & 63;
    end else begin
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
    end
    if (pick < 25) begin
      send_command(OP_WALL, x, y, $urandom_range(0, 3) == 0);
    end else if (pick < 32) begin
      cx = x;
      cy = y;
      send_command(OP_VIEW, x, y, $urandom_range(0, 1));
    end else if (pick < 82) begin
      send_command(OP_QUERY, x, y, $urandom_range(0, 1));
    end else begin
      send_command(OP_MARK, x, y, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int radii [6] = '{0, 31, 3, 1, 17, 8};
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_WALL;
    in_tile_x = '0;
    in_tile_y = '0;
    in_wall_bit = 1'b0;
    cfg_valid = 1'b0;
    cfg_sight_radius = '0;
    burst_left = 0;
    cur_radius = 8;
    cx = 32;
    cy = 32;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(OP_QUERY, 0, 0, 1'b0);
    send_command(OP_WALL, 1, 0, 1'b1);
    send_command(OP_WALL, 63, 63, 1'b0);
    send_command(OP_VIEW, 0, 0, 1'b0);
    send_command(OP_QUERY, 0, 0, 1'b1);
    send_command(OP_QUERY, 2, 0, 1'b0);
    send_command(OP_QUERY, 0, 8, 1'b0);
    send_command(OP_MARK, 63, 0, 1'b1);
    send_command(OP_QUERY, 63, 0, 1'b0);
    send_command(OP_VIEW, 63, 63, 1'b1);
    send_command(OP_QUERY, 0, 0, 1'b0);
    send_command(OP_QUERY, 63, 63, 1'b0);
    send_command(OP_QUERY, 55, 55, 1'b0);
    set_radius(0);
    send_command(OP_VIEW, 32, 32, 1'b0);
    send_command(OP_QUERY, 32, 32, 1'b0);
    send_command(OP_QUERY, 33, 32, 1'b0);
    set_radius(31);
    send_command(OP_VIEW, 0, 63, 1'b0);
    send_command(OP_QUERY, 30, 63, 1'b0);
    send_command(OP_QUERY, 0, 32, 1'b0);

    foreach (radii[p]) begin
      set_radius(radii[p]);
      for (int n = 0; n < 215; n++) begin
        if (n == 100) drain_results();
        random_command();
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
